[src/mswt_pkg.sv]
package mswt_pkg;

    // Size of the timer table; the slot field can address at most sixteen entries.
    localparam int TIMER_SLOTS  = 16;
    localparam int SLOT_FIELD_W = 4;
    localparam int SLOT_SPAN    = 1 << SLOT_FIELD_W;
    localparam int NUM_SLOTS    = (TIMER_SLOTS < SLOT_SPAN) ? TIMER_SLOTS : SLOT_SPAN;
    localparam int IDX_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 32;

    localparam logic [PERIOD_W-1:0] SLEEP_RESET = 32'd60;

    localparam logic [1:0] CMD_REGISTER   = 2'd0;
    localparam logic [1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [1:0] CMD_TICK       = 2'd2;

    localparam logic [1:0] KIND_REG_ACK   = 2'd0;
    localparam logic [1:0] KIND_UNREG_ACK = 2'd1;
    localparam logic [1:0] KIND_FIRED     = 2'd2;
    localparam logic [1:0] KIND_WAKE      = 2'd3;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   due;
    } t_mem_wr;

endpackage

[src/mswt_slot_store.sv]
module mswt_slot_store (
    input  logic                            i_clk,
    input  mswt_pkg::t_mem_wr               i_wr,
    input  logic [mswt_pkg::IDX_W-1:0]      i_rd_addr,
    output logic [mswt_pkg::PERIOD_W-1:0]   o_rd_period,
    output logic [mswt_pkg::TIME_W-1:0]     o_rd_due
);

    logic [mswt_pkg::PERIOD_W-1:0] r_period_mem [mswt_pkg::NUM_SLOTS];
    logic [mswt_pkg::TIME_W-1:0]   r_due_mem    [mswt_pkg::NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_period_mem[i_wr.addr] <= i_wr.period;
            r_due_mem[i_wr.addr]    <= i_wr.due;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_period <= r_period_mem[i_rd_addr];
        o_rd_due    <= r_due_mem[i_rd_addr];
    end

endmodule

[src/multi_slot_watchdog_timer.sv]
// Timer table with one-shot and periodic slots, driven by register, unregister and tick
// commands. Each of these holds the input off once accepted until its last result has been
// loaded into the output register. A register or unregister command goes from the accepting
// cycle to a state that loads its acknowledge. A tick goes from the accepting cycle to a
// state that steps the time counter, then scans every slot through the shared evaluation
// unit, which reads the slot store one entry a cycle while the output register can load,
// and ends in a state for the wake report. The acknowledge, scan and wake states wait while
// the output register is full and not taken. An unknown command is dropped in the cycle that
// accepts it. The sleep period register may be written at any cycle and resets to 60.
module multi_slot_watchdog_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: sleep period.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    // Commands.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,  // slot[3:0], interval[35:4], fire_once[36], zero pad
    input  logic [1:0]  i_s_tuser,  // cmd[1:0]
    // Results.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,  // which_slot[3:0], ok[4], next_wake[52:5], zero pad
    output logic [1:0]  o_m_tuser,  // kind[1:0]
    output logic        o_m_tlast
);

    localparam int IW = mswt_pkg::IDX_W;
    localparam int TW = mswt_pkg::TIME_W;
    localparam int PW = mswt_pkg::PERIOD_W;
    localparam int SW = mswt_pkg::SLOT_FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REG,
        S_UNREG,
        S_LOAD,
        S_SCAN,
        S_WAKE
    } t_state;

    t_state r_state;

    logic [PW-1:0] r_sleep;
    logic [TW-1:0] r_now;
    logic [TW-1:0] r_wake;
    logic          r_have;
    logic [IW-1:0] r_idx;

    logic [mswt_pkg::NUM_SLOTS-1:0] r_present;
    logic [mswt_pkg::NUM_SLOTS-1:0] r_armed;
    logic [mswt_pkg::NUM_SLOTS-1:0] r_single;

    logic [SW-1:0] r_slot;
    logic [PW-1:0] r_interval;
    logic          r_fire_once;

    logic          r_out_valid;
    logic [1:0]    r_out_kind;
    logic [SW-1:0] r_out_slot;
    logic          r_out_ok;
    logic [TW-1:0] r_out_wake;
    logic          r_out_last;

    logic [PW-1:0] rd_period;
    logic [TW-1:0] rd_due;

    mswt_pkg::t_mem_wr mem_wr;
    logic [IW-1:0]     rd_addr;

    logic          can_load;
    logic          load_out;
    logic [PW-1:0] addend;
    logic [TW-1:0] sum;
    logic [TW-1:0] cmp_a;
    logic [TW-1:0] cmp_b;
    logic          cmp_le;
    logic          in_table;
    logic [IW-1:0] cmd_addr;
    logic          reg_ok;
    logic          fire;
    logic          cand_valid;
    logic [TW-1:0] cand;
    logic          take;
    logic          last_idx;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_wake, r_out_ok, r_out_slot};
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;

    assign can_load = !r_out_valid || i_m_tready;
    assign in_table = int'(r_slot) < mswt_pkg::TIMER_SLOTS;
    assign cmd_addr = r_slot[IW-1:0];
    assign reg_ok   = in_table && (r_interval != '0) && !r_present[cmd_addr];
    assign last_idx = (r_idx == IW'(mswt_pkg::NUM_SLOTS - 1));

    // A result enters the output register in this cycle.
    assign load_out = can_load && ((r_state == S_REG) || (r_state == S_UNREG) ||
                                   (r_state == S_WAKE) || ((r_state == S_SCAN) && fire));

    // Shared adder: the time counter plus an interval, a period, the sleep period or one.
    always_comb begin
        case (r_state)
            S_REG:   addend = r_interval;
            S_LOAD:  addend = PW'(1);
            S_SCAN:  addend = rd_period;
            S_WAKE:  addend = r_sleep;
            default: addend = '0;
        endcase
        sum = r_now + {{(TW - PW){1'b0}}, addend};
    end

    // Per-slot evaluation. A fired periodic slot offers its new due time to the running
    // minimum; a fired one-shot slot offers nothing.
    assign fire       = r_armed[r_idx] && (rd_due <= r_now);
    assign cand       = fire ? sum : rd_due;
    assign cand_valid = fire ? !r_single[r_idx] : r_armed[r_idx];

    // Shared minimum comparator.
    always_comb begin
        if (r_state == S_WAKE) begin
            cmp_a = r_wake;
            cmp_b = sum;
        end else begin
            cmp_a = cand;
            cmp_b = r_wake;
        end
        cmp_le = (cmp_a <= cmp_b);
    end

    assign take = cand_valid && (!r_have || cmp_le);

    always_comb begin
        mem_wr        = '0;
        mem_wr.period = r_interval;
        mem_wr.due    = sum;
        mem_wr.addr   = cmd_addr;
        if (r_state == S_REG) begin
            mem_wr.en = can_load && reg_ok;
        end else if (r_state == S_SCAN) begin
            mem_wr.en     = can_load && fire && !r_single[r_idx];
            mem_wr.addr   = r_idx;
            mem_wr.period = rd_period;
        end
    end

    // The next slot is read while the current one is evaluated.
    assign rd_addr = (r_state == S_SCAN && can_load && !last_idx) ? r_idx + IW'(1) : r_idx;

    mswt_slot_store u_store (
        .i_clk       (i_clk),
        .i_wr        (mem_wr),
        .i_rd_addr   (rd_addr),
        .o_rd_period (rd_period),
        .o_rd_due    (rd_due)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sleep     <= mswt_pkg::SLEEP_RESET;
            r_now       <= '0;
            r_have      <= 1'b0;
            r_idx       <= '0;
            r_present   <= '0;
            r_armed     <= '0;
            r_single    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sleep <= i_cfg_data;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_slot      <= i_s_tdata[3:0];
                        r_interval  <= i_s_tdata[35:4];
                        r_fire_once <= i_s_tdata[36];
                        r_idx       <= '0;
                        case (i_s_tuser)
                            mswt_pkg::CMD_REGISTER:   r_state <= S_REG;
                            mswt_pkg::CMD_UNREGISTER: r_state <= S_UNREG;
                            mswt_pkg::CMD_TICK:       r_state <= S_LOAD;
                            default:                  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_REG: begin
                    if (can_load) begin
                        if (reg_ok) begin
                            r_present[cmd_addr] <= 1'b1;
                            r_armed[cmd_addr]   <= 1'b1;
                            r_single[cmd_addr]  <= r_fire_once;
                        end
                        r_out_kind  <= mswt_pkg::KIND_REG_ACK;
                        r_out_slot  <= r_slot;
                        r_out_ok    <= reg_ok;
                        r_out_wake  <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_UNREG: begin
                    if (can_load) begin
                        if (in_table) begin
                            r_present[cmd_addr] <= 1'b0;
                            r_armed[cmd_addr]   <= 1'b0;
                            r_single[cmd_addr]  <= 1'b0;
                        end
                        r_out_kind  <= mswt_pkg::KIND_UNREG_ACK;
                        r_out_slot  <= r_slot;
                        r_out_ok    <= in_table && r_present[cmd_addr];
                        r_out_wake  <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_LOAD: begin
                    r_now   <= sum;
                    r_have  <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (can_load) begin
                        if (fire) begin
                            if (r_single[r_idx]) begin
                                r_armed[r_idx] <= 1'b0;
                            end
                            r_out_kind  <= mswt_pkg::KIND_FIRED;
                            r_out_slot  <= SW'(r_idx);
                            r_out_ok    <= 1'b1;
                            r_out_wake  <= '0;
                            r_out_last  <= 1'b0;
                        end
                        if (take) begin
                            r_wake <= cand;
                            r_have <= 1'b1;
                        end
                        if (last_idx) begin
                            r_state <= S_WAKE;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_WAKE: begin
                    if (can_load) begin
                        r_out_kind  <= mswt_pkg::KIND_WAKE;
                        r_out_slot  <= '0;
                        r_out_ok    <= 1'b1;
                        r_out_wake  <= (r_have && cmp_le) ? r_wake : sum;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/mswt_checker.sv]
module mswt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A known command keeps the block busy in the next cycle.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && ((i_s_tuser == mswt_pkg::CMD_REGISTER) ||
                                      (i_s_tuser == mswt_pkg::CMD_UNREGISTER) ||
                                      (i_s_tuser == mswt_pkg::CMD_TICK)))
            |=> !o_s_tready)
        else $error("input ready right after a command transaction");

    // While a fire result is pending, the tick is still in progress.
    a_no_accept_mid_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input ready while a tick is still producing results");

    // A wake report always closes its tick and carries slot zero with ok set.
    a_wake_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == mswt_pkg::KIND_WAKE))
            |-> (o_m_tlast && o_m_tdata[4] && (o_m_tdata[3:0] == 4'd0)))
        else $error("malformed wake report");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready)
            |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("result changed while stalled");

endmodule

bind multi_slot_watchdog_timer mswt_checker u_mswt_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int TW = mswt_pkg::TIME_W;
    localparam int PW = mswt_pkg::PERIOD_W;
    localparam int NS = mswt_pkg::NUM_SLOTS;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [1:0]    kind;
        logic [3:0]    slot;
        logic          ok;
        logic [TW-1:0] wake;
        logic          last;
    } t_timer_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    // Shadow copy of the timer table and its sleep period.
    logic [PW-1:0] tm_sleep = mswt_pkg::SLEEP_RESET;
    logic [TW-1:0] tm_now = '0;
    logic          tm_present [NS];
    logic          tm_armed [NS];
    logic          tm_single [NS];
    logic [PW-1:0] tm_period [NS];
    logic [TW-1:0] tm_due [NS];

    t_timer_out timer_out_q[$];

    int cycle_count = 0;
    int mismatches = 0;
    int sent_count = 0;
    int tick_count = 0;
    int fires_seen = 0;
    int wakes_seen = 0;
    int cfg_writes = 0;
    int burst_left = 0;
    int rx_span = 0;
    int rx_mode = 0;

    multi_slot_watchdog_timer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < NS; i++) begin
            tm_present[i] = 1'b0;
            tm_armed[i]   = 1'b0;
            tm_single[i]  = 1'b0;
        end
    end

    // Applies one command to the shadow table and queues the results it causes.
    function automatic void step_timer_table(input logic [1:0] cmd, input logic [3:0] slot,
                                             input logic [31:0] ival, input logic single);
        t_timer_out r;
        logic [TW-1:0] wake;
        r = '0;
        r.slot = slot;
        r.last = 1'b1;
        case (cmd)
            mswt_pkg::CMD_REGISTER: begin
                r.kind = mswt_pkg::KIND_REG_ACK;
                if (slot < NS && ival != 0 && !tm_present[slot]) begin
                    tm_present[slot] = 1'b1;
                    tm_armed[slot]   = 1'b1;
                    tm_single[slot]  = single;
                    tm_period[slot]  = ival;
                    tm_due[slot]     = tm_now + ival;
                    r.ok = 1'b1;
                end
                timer_out_q.push_back(r);
            end
            mswt_pkg::CMD_UNREGISTER: begin
                r.kind = mswt_pkg::KIND_UNREG_ACK;
                if (slot < NS) begin
                    r.ok = tm_present[slot];
                    tm_present[slot] = 1'b0;
                    tm_armed[slot]   = 1'b0;
                    tm_single[slot]  = 1'b0;
                end
                timer_out_q.push_back(r);
            end
            mswt_pkg::CMD_TICK: begin
                tm_now = tm_now + 1'b1;
                for (int i = 0; i < NS; i++) begin
                    if (tm_armed[i] && tm_due[i] <= tm_now) begin
                        r = '0;
                        r.kind = mswt_pkg::KIND_FIRED;
                        r.slot = i[3:0];
                        r.ok   = 1'b1;
                        timer_out_q.push_back(r);
                        if (tm_single[i])
                            tm_armed[i] = 1'b0;
                        else
                            tm_due[i] = tm_now + tm_period[i];
                    end
                end
                wake = tm_now + tm_sleep;
                for (int i = 0; i < NS; i++) begin
                    if (tm_armed[i] && tm_due[i] <= wake)
                        wake = tm_due[i];
                end
                r = '0;
                r.kind = mswt_pkg::KIND_WAKE;
                r.ok   = 1'b1;
                r.wake = wake;
                r.last = 1'b1;
                timer_out_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [TW-1:0] want,
                               input logic [TW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge i_clk) begin
        t_timer_out exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (timer_out_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual kind %0d slot %0d",
                         $time, o_m_tuser, o_m_tdata[3:0]);
                mismatches++;
            end else begin
                exp_r = timer_out_q.pop_front();
                check_field("kind", TW'(exp_r.kind), TW'(o_m_tuser));
                check_field("which_slot", TW'(exp_r.slot), TW'(o_m_tdata[3:0]));
                check_field("ok", TW'(exp_r.ok), TW'(o_m_tdata[4]));
                check_field("next_wake", exp_r.wake, o_m_tdata[52:5]);
                check_field("last", TW'(exp_r.last), TW'(o_m_tlast));
                if (exp_r.kind == mswt_pkg::KIND_FIRED)
                    fires_seen++;
                if (exp_r.kind == mswt_pkg::KIND_WAKE)
                    wakes_seen++;
            end
        end
        if (rx_span == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_span <= $urandom_range(8, 60);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            0: i_m_tready <= 1'b1;
            1: i_m_tready <= 1'($urandom_range(0, 1));
            default: i_m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, timer_out_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Bursts of random length separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [3:0] slot,
                            input logic [31:0] ival, input logic single);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {3'b000, single, ival, slot};
        do @(posedge i_clk); while (!o_s_tready);
        step_timer_table(cmd, slot, ival, single);
        sent_count++;
        if (cmd == mswt_pkg::CMD_TICK)
            tick_count++;
        pace_sender();
    endtask

    // Waits until every queued result has arrived, then keeps the sender idle before returning.
    task automatic settle_table();
        i_s_tvalid <= 1'b0;
        while (timer_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_sleep_period(input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tm_sleep = value;
        cfg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_commands();
        send_cmd(mswt_pkg::CMD_REGISTER, 4'd0, 32'd0, 1'b0);            // zero interval refused
        send_cmd(mswt_pkg::CMD_REGISTER, 4'd0, 32'd3, 1'b0);
        send_cmd(mswt_pkg::CMD_REGISTER, 4'd0, 32'd5, 1'b1);            // slot in use
        send_cmd(mswt_pkg::CMD_REGISTER, 4'd15, 32'hFFFF_FFFF, 1'b1);
        send_cmd(mswt_pkg::CMD_REGISTER, 4'd5, 32'd1, 1'b1);
        send_cmd(mswt_pkg::CMD_REGISTER, 4'd3, 32'h5555_5555, 1'b0);
        send_cmd(mswt_pkg::CMD_REGISTER, 4'd12, 32'hAAAA_AAAA, 1'b1);
        send_cmd(mswt_pkg::CMD_UNREGISTER, 4'd7, $urandom(), 1'b1);     // absent slot
        send_cmd(CMD_UNKNOWN, 4'd10, $urandom(), 1'b1);                 // ignored command
        repeat (4)
            send_cmd(mswt_pkg::CMD_TICK, 4'($urandom_range(0, 15)), $urandom(),
                     1'($urandom_range(0, 1)));
        // Slot 5 has fired once and is spent, but it still holds its place.
        send_cmd(mswt_pkg::CMD_REGISTER, 4'd5, 32'd2, 1'b0);
        send_cmd(mswt_pkg::CMD_UNREGISTER, 4'd5, 32'd0, 1'b0);
        send_cmd(mswt_pkg::CMD_REGISTER, 4'd5, 32'd2, 1'b0);
        repeat (2) send_cmd(mswt_pkg::CMD_TICK, 4'd9, $urandom(), 1'b0);
        send_cmd(mswt_pkg::CMD_UNREGISTER, 4'd0, 32'd0, 1'b0);
        send_cmd(mswt_pkg::CMD_UNREGISTER, 4'd3, 32'd0, 1'b0);
        send_cmd(mswt_pkg::CMD_UNREGISTER, 4'd12, 32'd0, 1'b0);
        send_cmd(mswt_pkg::CMD_UNREGISTER, 4'd15, 32'd0, 1'b0);
        send_cmd(mswt_pkg::CMD_UNREGISTER, 4'd5, 32'd0, 1'b0);
        send_cmd(mswt_pkg::CMD_TICK, 4'd0, 32'd0, 1'b0);
        settle_table();
    endtask

    // Tries sleep periods 0, 1, all ones and 60; zero caps every wake at the current time.
    task automatic test_sleep_extremes();
        logic [31:0] settings [4];
        settings[0] = 32'd0;
        settings[1] = 32'd1;
        settings[2] = 32'hFFFF_FFFF;
        settings[3] = mswt_pkg::SLEEP_RESET;
        for (int k = 0; k < 4; k++) begin
            write_sleep_period(settings[k]);
            send_cmd(mswt_pkg::CMD_REGISTER, 4'd8, $urandom_range(2, 5), 1'b0);
            repeat (3) send_cmd(mswt_pkg::CMD_TICK, 4'd0, $urandom(), 1'b0);
            send_cmd(mswt_pkg::CMD_UNREGISTER, 4'd8, 32'd0, 1'b0);
            settle_table();
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int pick;
        int sel;
        logic [1:0]  cmd;
        logic [31:0] ival;
        for (int n = 0; n < n_items; n++) begin
            if (n > 0 && n % (n_items / 4) == 0) begin
                settle_table();
                if (n == n_items / 2)
                    write_sleep_period($urandom());
                else
                    write_sleep_period($urandom_range(1, 20));
            end
            pick = $urandom_range(0, 99);
            if (pick < 38)
                cmd = mswt_pkg::CMD_TICK;
            else if (pick < 72)
                cmd = mswt_pkg::CMD_REGISTER;
            else if (pick < 94)
                cmd = mswt_pkg::CMD_UNREGISTER;
            else
                cmd = CMD_UNKNOWN;
            sel = $urandom_range(0, 9);
            if (cmd != mswt_pkg::CMD_REGISTER || sel >= 8)
                ival = $urandom();
            else if (sel == 7)
                ival = 32'd0;
            else
                ival = $urandom_range(1, 6);
            send_cmd(cmd, 4'($urandom_range(0, 15)), ival, 1'($urandom_range(0, 1)));
            // Once in a while the sender holds off until the table has drained.
            if ($urandom_range(0, 39) == 0) begin
                i_s_tvalid <= 1'b0;
                do @(posedge i_clk); while (timer_out_q.size() != 0);
            end
        end
        settle_table();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_commands();
        test_sleep_extremes();
        test_random_traffic(176);
        $display("Sent %0d commands including %0d ticks; checked %0d fires and %0d wake reports.",
                 sent_count, tick_count, fires_seen, wakes_seen);
        $display("Sleep period written %0d times, including zero and the full 32-bit value.",
                 cfg_writes);
        if (mismatches == 0 && timer_out_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches, timer_out_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
